[design/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned OUT_TDATA_W    = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

[design/sitda_cell.sv]
// One BCD digit cell of the shift-and-add-3 chain.
module sitda_cell (
  input  logic                              clk_i,
  input  sitda_pkg::cell_mode_e             mode_i,
  input  logic                              bit_i,
  input  logic [sitda_pkg::DIGIT_W-1:0]     digit_i,
  output logic                              bit_o,
  output logic [sitda_pkg::DIGIT_W-1:0]     digit_o
);

  logic [sitda_pkg::DIGIT_W-1:0] digit_q;
  logic [sitda_pkg::DIGIT_W-1:0] digit_d;
  logic [sitda_pkg::DIGIT_W-1:0] adj;

  // add 3 before the shift so the digit carries over correctly at ten
  assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o = adj[sitda_pkg::DIGIT_W-1];

  always_comb begin
    unique case (mode_i)
      sitda_pkg::CELL_CLEAR:  digit_d = '0;
      sitda_pkg::CELL_DABBLE: digit_d = {adj[sitda_pkg::DIGIT_W-2:0], bit_i};
      sitda_pkg::CELL_SHIFT:  digit_d = digit_i;
      default:                digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

[design/signed_int_to_decimal_ascii_core.sv]
// Top level: signed integer in, decimal ASCII characters out, one per transfer.
//
//  channel   | dir | payload                                  | handshake
//  s_axis    | in  | tdata: value (VALUE_BITS, signed)        | tvalid/tready
//  m_axis    | out | tdata: character (7b) + zero pad; tlast  | tvalid/tready
//
// One item at a time: accept the value, shift its magnitude through a row of BCD
// digit cells, drop leading zeros by moving the row up, then emit the characters,
// sign first.
// Reset clears the control state; the cells are cleared on each accept.
// A stall on m_axis holds the character register, and the cell row while emitting.
module signed_int_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata,   // [VALUE_BITS-1:0] value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sitda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [6:0] character, [7] zero
  output logic                               m_axis_tlast
);

  localparam int unsigned DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned REM_W  = $clog2(DIGITS + 1);
  localparam int unsigned DW     = sitda_pkg::DIGIT_W;

  sitda_pkg::state_e     state_q, state_d;
  sitda_pkg::cell_mode_e cell_mode;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;

  logic                           out_valid_q, out_valid_d;
  logic [sitda_pkg::CHAR_W-1:0]   out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;

  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg;
  logic                  out_free;

  logic [DIGITS:0]       carry;
  logic [DW-1:0]         digit [DIGITS];
  logic [DW-1:0]         top_digit;

  assign in_val   = s_axis_tdata[VALUE_BITS-1:0];
  assign in_neg   = in_val[VALUE_BITS-1];
  assign out_free = !out_valid_q || m_axis_tready;
  assign top_digit = digit[DIGITS-1];

  // cell row, index 0 is the least significant digit
  assign carry[0] = mag_q[VALUE_BITS-1];
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    logic [DW-1:0] below;
    if (k == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = digit[k-1];
    end
    sitda_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (cell_mode),
      .bit_i   (carry[k]),
      .digit_i (below),
      .bit_o   (carry[k+1]),
      .digit_o (digit[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    cell_mode   = sitda_pkg::CELL_HOLD;
    s_axis_tready = 1'b0;

    unique case (state_q)
      sitda_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cell_mode = sitda_pkg::CELL_CLEAR;
          neg_d     = in_neg;
          mag_d     = in_neg ? (~in_val + 1'b1) : in_val;
          cnt_d     = CNT_W'(VALUE_BITS - 1);
          rem_d     = REM_W'(DIGITS);
          state_d   = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        cell_mode = sitda_pkg::CELL_DABBLE;
        mag_d     = {mag_q[VALUE_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = sitda_pkg::ST_SKIP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      sitda_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == '0 && rem_q > REM_W'(1)) begin
          cell_mode = sitda_pkg::CELL_SHIFT;
          rem_d     = rem_q - 1'b1;
        end else begin
          state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_EMIT: begin
        if (out_free) begin
          cell_mode   = sitda_pkg::CELL_SHIFT;
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CHAR_ZERO + {3'b000, top_digit};
          out_last_d  = (rem_q == REM_W'(1));
          rem_d       = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = sitda_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sitda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == sitda_pkg::CHAR_MINUS ||
                       (m_axis_tdata[6:0] >= 7'h30 && m_axis_tdata[6:0] <= 7'h39)))
    else $error("output character is neither digit nor minus");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[6:0] == sitda_pkg::CHAR_MINUS) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == sitda_pkg::ST_CONV)
    else $error("accepted item did not start conversion");

  a_top_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitda_pkg::ST_SKIP || state_q == sitda_pkg::ST_EMIT) |-> top_digit <= 4'd9)
    else $error("top digit cell holds an invalid BCD code");

endmodule

[test/signed_int_to_decimal_ascii_core_tb.sv]
// Self-checking testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_core_tb;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] ch;
    logic                         last;
  } text_char_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [VALUE_W-1:0]                s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [sitda_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tlast;

  text_char_t  text_chars_due[$];
  text_char_t  due_char;
  int unsigned char_mismatches = 0;
  int unsigned quiet_cycles    = 0;
  bit          no_stall        = 1'b0;

  signed_int_to_decimal_ascii_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expected text of one value: sign first, then digits, most significant first.
  task automatic push_decimal_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs [12];
    int                 n;
    text_char_t         c;
    n   = 0;
    mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
    do begin
      digs[n] = 4'(mag % 32'd10);
      mag     = mag / 32'd10;
      n++;
    end while (mag != '0);
    if (value[VALUE_W-1]) begin
      c.ch   = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      text_chars_due.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch   = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digs[i]);
      c.last = (i == 0);
      text_chars_due.push_back(c);
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    @(negedge clk_i);
    if (!no_stall && $urandom_range(99) < 10) begin
      gap = $urandom_range(60, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    push_decimal_text(value);
  endtask

  // Hold the sender off until every outstanding character has arrived.
  task automatic drain_text;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (text_chars_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(15))
      0:       v = '0;
      1:       v = {1'b1, {(VALUE_W-1){1'b0}}};
      2:       v = {1'b0, {(VALUE_W-1){1'b1}}};
      3:       v = '1;
      default: begin
        v = $urandom >> $urandom_range(VALUE_W - 1, 0);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  task automatic test_extremes;
    logic [VALUE_W-1:0] vals [18];
    vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             -32'sd1000000000, 32'd999999999, 32'd123456789, -32'sd123456789,
             32'h5555_5555, 32'hAAAA_AAAA};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_drain_pause;
    repeat (4) begin
      repeat (5) send_value(random_value());
      drain_text();
    end
  endtask

  task automatic test_steady_stream;
    no_stall = 1'b1;
    repeat (100) send_value(random_value());
    no_stall = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= no_stall || ($urandom_range(99) >= 10);
  end

  task automatic note_mismatch(input string what);
    char_mismatches++;
    if (char_mismatches <= MAX_REPORTS)
      $display("%s: expected char %h last %b, got tdata %h last %b", what,
               due_char.ch, due_char.last, m_axis_tdata, m_axis_tlast);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (text_chars_due.size() == 0) begin
        due_char = '0;
        note_mismatch("unexpected transfer");
      end else begin
        due_char = text_chars_due.pop_front();
        if (m_axis_tdata[sitda_pkg::CHAR_W-1:0] !== due_char.ch
            || m_axis_tdata[sitda_pkg::OUT_TDATA_W-1] !== 1'b0
            || m_axis_tlast !== due_char.last)
          note_mismatch("wrong character");
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_random_mix(120);
    test_drain_pause();
    test_steady_stream();
    test_random_mix(72);
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (char_mismatches == 0 && text_chars_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
